@@ src/thp_pkg.sv @@
package thp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL    = 3'd4;

  // humidity ceiling before the final shift (100 %RH)
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // factory calibration words
  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_nine;
    logic [63:0] hum_cal;
  } cal_t;

  // one reading set after temperature compensation
  typedef struct packed {
    logic [31:0] tfine;
    logic [31:0] temp;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
  } meas_t;

  // arithmetic shift right on 32-bit and 64-bit patterns
  function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] n);
    logic signed [31:0] s;
    s = $signed(v) >>> n;
    return s;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] v, input logic [5:0] n);
    logic signed [63:0] s;
    s = $signed(v) >>> n;
    return s;
  endfunction

endpackage

@@ src/thp_if.sv @@
interface thp_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] adc_temp;
  logic [19:0] adc_press;
  logic [15:0] adc_hum;
  modport source (output valid, output adc_temp, output adc_press,
                  output adc_hum, input ready);
  modport sink (input valid, input adc_temp, input adc_press,
                input adc_hum, output ready);
endinterface

interface thp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic        [16:0] humidity_q22_10;
  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output humidity_q22_10, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input humidity_q22_10, output ready);
endinterface

interface thp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [thp_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/thp_front.sv @@
module thp_front (
  input  logic           clk,
  input  logic           rst,
  thp_in_if.sink         sample,
  input  thp_pkg::cal_t  cal,
  input  logic           full,
  output logic           push,
  output thp_pkg::meas_t push_data
);
  import thp_pkg::*;

  localparam int unsigned Stages = 5;

  logic [Stages:1] vld;
  logic            adv;

  logic        [15:0] t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;

  logic signed [17:0] f1_df;
  logic signed [16:0] f1_d2;
  logic signed [33:0] f2_v1p;
  logic signed [33:0] f2_sq;
  logic        [31:0] f3_v1;
  logic        [31:0] f3_v2p;
  logic        [31:0] f4_tfine;
  logic        [31:0] f5_tfine;
  logic        [31:0] f5_temp;
  logic        [19:0] rp [1:Stages];
  logic        [15:0] rh [1:Stages];

  assign t1 = cal.temp_cal[15:0];
  assign t2 = $signed(cal.temp_cal[31:16]);
  assign t3 = $signed(cal.temp_cal[47:32]);

  // whole front stalls only when its last stage cannot drain
  assign adv          = !vld[Stages] || !full;
  assign sample.ready = adv;
  assign push         = vld[Stages] && !full;
  assign push_data    = '{tfine: f5_tfine, temp: f5_temp, raw_p: rp[Stages], raw_h: rh[Stages]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-1:1], sample.valid};
    end
  end

  // temperature compensation pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_df    <= $signed({1'b0, sample.adc_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
      f1_d2    <= $signed({1'b0, sample.adc_temp[19:4]}) - $signed({1'b0, t1});
      f2_v1p   <= f1_df * t2;
      f2_sq    <= f1_d2 * f1_d2;
      f3_v1    <= sra32(f2_v1p[31:0], 5'd11);
      f3_v2p   <= sra32(f2_sq[31:0], 5'd12) * {{16{t3[15]}}, t3};
      f4_tfine <= f3_v1 + sra32(f3_v2p, 5'd14);
      f5_tfine <= f4_tfine;
      f5_temp  <= sra32(f4_tfine + {f4_tfine[29:0], 2'b00} + 32'd128, 5'd8);
      rp[1]    <= sample.adc_press;
      rh[1]    <= sample.adc_hum;
      for (int i = 2; i <= Stages; i++) begin
        rp[i] <= rp[i-1];
        rh[i] <= rh[i-1];
      end
    end
  end

endmodule

@@ src/thp_queue.sv @@
module thp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  thp_pkg::meas_t push_data,
  output logic           full,
  input  logic           pop,
  output thp_pkg::meas_t head,
  output logic           head_valid
);
  import thp_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  meas_t           mem [DEPTH];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers wrap at DEPTH, count tracks occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/thp_back.sv @@
module thp_back (
  input  logic           clk,
  input  logic           rst,
  input  thp_pkg::cal_t  cal,
  input  thp_pkg::meas_t head,
  input  logic           head_valid,
  output logic           pop,
  thp_out_if.source      result
);
  import thp_pkg::*;

  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivStart = 9;                  // stage holding divider operands
  localparam int unsigned DivEnd   = DivStart + DivSteps; // quotient ready
  localparam int unsigned HumDone  = 11;
  localparam int unsigned Lat      = DivEnd + 6;         // output register

  logic [Lat:1] vld;
  logic         adv;

  // calibration fields
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic        [7:0]  h1, h3, h6;
  logic        [15:0] h2;
  logic        [11:0] h4, h5;

  assign p1 = cal.press_low[15:0];
  assign p2 = $signed(cal.press_low[31:16]);
  assign p3 = $signed(cal.press_low[47:32]);
  assign p4 = $signed(cal.press_low[63:48]);
  assign p5 = $signed(cal.press_high[15:0]);
  assign p6 = $signed(cal.press_high[31:16]);
  assign p7 = $signed(cal.press_high[47:32]);
  assign p8 = $signed(cal.press_high[63:48]);
  assign p9 = $signed(cal.press_nine);
  assign h1 = cal.hum_cal[7:0];
  assign h2 = cal.hum_cal[23:8];
  assign h3 = cal.hum_cal[31:24];
  assign h4 = cal.hum_cal[43:32];
  assign h5 = cal.hum_cal[55:44];
  assign h6 = cal.hum_cal[63:56];

  // stage registers
  logic signed [32:0] s1_a;
  logic        [31:0] s1_x;
  logic        [20:0] s1_p0, s2_p0, s3_p0, s4_p0, s5_p0;
  logic        [15:0] s1_rawh, s2_rawh;
  logic        [63:0] s2_aa;
  logic signed [48:0] s2_ap5, s3_ap5, s4_ap5;
  logic signed [48:0] s2_ap2, s3_ap2, s4_ap2;
  logic        [31:0] s2_h5x, s2_xh6, s2_xh3;
  logic signed [48:0] s3_p6l, s3_p3l;
  logic        [31:0] s3_p6h, s3_p3h;
  logic        [31:0] s3_ha, s4_ha, s5_ha, s6_ha, s7_ha;
  logic        [31:0] s3_hb, s3_hc, s4_hbc, s5_he, s6_he2, s7_hf;
  logic        [63:0] s4_aap6, s4_aap3, s5_b, s5_a2, s6_m, s6_n0;
  logic        [47:0] s7_ml;
  logic        [31:0] s7_mh;
  logic        [43:0] s7_nl;
  logic        [31:0] s7_nh;
  logic        [63:0] s8_mp, s8_np;
  logic        [31:0] s8_v, s9_v, s10_v, s9_ss, s10_t;
  logic        [63:0] s74_p, s75_p, s76_p, s77_p, s78_p;
  logic               s74_zero, s75_zero, s76_zero, s77_zero, s78_zero;
  logic        [63:0] s75_sql;
  logic        [31:0] s75_sqx;
  logic signed [48:0] s75_p8l;
  logic        [31:0] s75_p8h;
  logic        [63:0] s76_sq, s76_c2, s77_c2, s78_c2, s78_c1;
  logic signed [48:0] s77_sl;
  logic        [31:0] s77_sh;
  logic        [31:0] s79_press;
  logic        [31:0] tp [1:Lat];
  logic        [16:0] hp [HumDone:Lat];

  // divider pipeline, one quotient bit per stage
  logic [30:0] div_rem  [0:DivSteps-1];
  logic [30:0] div_dd   [0:DivSteps-1];
  logic [63:0] div_nq   [0:DivSteps];
  logic        div_neg  [0:DivSteps];
  logic        div_zero [0:DivSteps];

  // combinational helpers
  logic [30:0] d_sgn, d_mag;
  logic [63:0] n_mag;
  logic [31:0] hum_v, hum_c;
  logic [63:0] ps, press_sum, press_r;

  // all stages move together; output register is the last stage
  assign adv          = !vld[Lat] || result.ready;
  assign pop          = adv && head_valid;
  assign result.valid = vld[Lat];
  assign result.temperature_centi = tp[Lat];
  assign result.pressure_q24_8    = s79_press;
  assign result.humidity_q22_10   = hp[Lat];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-1:1], head_valid};
    end
  end

  // divider operands: 31-bit signed divisor, 64-bit signed dividend
  always_comb begin
    d_sgn = s8_mp[63:33];
    d_mag = d_sgn[30] ? (31'd0 - d_sgn) : d_sgn;
    n_mag = s8_np[63] ? (64'd0 - s8_np) : s8_np;
  end

  // humidity final subtract and clamp to 0..100 %RH
  always_comb begin
    hum_v = s10_v - sra32(s10_t, 5'd4);
    priority if (hum_v[31]) begin
      hum_c = '0;
    end else if (hum_v > HUM_MAX) begin
      hum_c = HUM_MAX;
    end else begin
      hum_c = hum_v;
    end
  end

  // pressure tail
  always_comb begin
    ps        = sra64(s74_p, 6'd13);
    press_sum = s78_p + s78_c1 + s78_c2;
    press_r   = sra64(press_sum, 6'd8) + ({{48{p7[15]}}, p7} << 4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: offsets from fine temperature
      s1_a    <= $signed({head.tfine[31], head.tfine}) - 33'sd128000;
      s1_x    <= head.tfine - 32'd76800;
      s1_p0   <= 21'd1048576 - {1'b0, head.raw_p};
      s1_rawh <= head.raw_h;
      // stage 2: first products
      s2_aa   <= s1_a * s1_a;
      s2_ap5  <= s1_a * p5;
      s2_ap2  <= s1_a * p2;
      s2_p0   <= s1_p0;
      s2_rawh <= s1_rawh;
      s2_h5x  <= s1_x * {{20{h5[11]}}, h5};
      s2_xh6  <= s1_x * {{24{h6[7]}}, h6};
      s2_xh3  <= s1_x * {24'd0, h3};
      // stage 3: split 64x16 products, humidity terms
      s3_p6l  <= $signed({1'b0, s2_aa[31:0]}) * p6;
      s3_p6h  <= s2_aa[63:32] * {{16{p6[15]}}, p6};
      s3_p3l  <= $signed({1'b0, s2_aa[31:0]}) * p3;
      s3_p3h  <= s2_aa[63:32] * {{16{p3[15]}}, p3};
      s3_ap5  <= s2_ap5;
      s3_ap2  <= s2_ap2;
      s3_p0   <= s2_p0;
      s3_ha   <= sra32(({16'd0, s2_rawh} << 14) - ({{20{h4[11]}}, h4} << 20)
                       - s2_h5x + 32'd16384, 5'd15);
      s3_hb   <= sra32(s2_xh6, 5'd10);
      s3_hc   <= sra32(s2_xh3, 5'd11) + 32'd32768;
      // stage 4: join partial products
      s4_aap6 <= {{15{s3_p6l[48]}}, s3_p6l} + {s3_p6h, 32'd0};
      s4_aap3 <= {{15{s3_p3l[48]}}, s3_p3l} + {s3_p3h, 32'd0};
      s4_ap5  <= s3_ap5;
      s4_ap2  <= s3_ap2;
      s4_p0   <= s3_p0;
      s4_ha   <= s3_ha;
      s4_hbc  <= s3_hb * s3_hc;
      // stage 5: numerator and divisor terms
      s5_b    <= s4_aap6 + ({{15{s4_ap5[48]}}, s4_ap5} << 17)
                 + ({{48{p4[15]}}, p4} << 35);
      s5_a2   <= sra64(s4_aap3, 6'd8) + ({{15{s4_ap2[48]}}, s4_ap2} << 12);
      s5_p0   <= s4_p0;
      s5_ha   <= s4_ha;
      s5_he   <= sra32(s4_hbc, 5'd10) + 32'd2097152;
      // stage 6
      s6_m    <= 64'h0000_8000_0000_0000 + s5_a2;
      s6_n0   <= {12'd0, s5_p0, 31'd0} - s5_b;
      s6_ha   <= s5_ha;
      s6_he2  <= s5_he * {{16{h2[15]}}, h2};
      // stage 7: scale by P1 and by 3125 in halves
      s7_ml   <= s6_m[31:0] * p1;
      s7_mh   <= s6_m[63:32] * {16'd0, p1};
      s7_nl   <= s6_n0[31:0] * 12'd3125;
      s7_nh   <= s6_n0[63:32] * 32'd3125;
      s7_ha   <= s6_ha;
      s7_hf   <= sra32(s6_he2 + 32'd8192, 5'd14);
      // stage 8
      s8_mp   <= {16'd0, s7_ml} + {s7_mh, 32'd0};
      s8_np   <= {20'd0, s7_nl} + {s7_nh, 32'd0};
      s8_v    <= s7_ha * s7_hf;
      // stage 9: divider load, humidity square
      div_rem[0]  <= '0;
      div_dd[0]   <= d_mag;
      div_nq[0]   <= n_mag;
      div_neg[0]  <= s8_np[63] ^ s8_mp[63];
      div_zero[0] <= (d_sgn == '0);
      s9_v    <= s8_v;
      s9_ss   <= sra32(s8_v, 5'd15) * sra32(s8_v, 5'd15);
      // stages 10, 11: humidity finish
      s10_v   <= s9_v;
      s10_t   <= sra32(s9_ss, 5'd7) * {24'd0, h1};
      hp[HumDone] <= hum_c[28:12];
      // after divider: sign, then correction terms
      s74_p    <= div_neg[DivSteps] ? (64'd0 - div_nq[DivSteps]) : div_nq[DivSteps];
      s74_zero <= div_zero[DivSteps];
      s75_sql  <= ps[31:0] * ps[31:0];
      s75_sqx  <= ps[31:0] * ps[63:32];
      s75_p8l  <= $signed({1'b0, s74_p[31:0]}) * p8;
      s75_p8h  <= s74_p[63:32] * {{16{p8[15]}}, p8};
      s75_p    <= s74_p;
      s75_zero <= s74_zero;
      s76_sq   <= s75_sql + {s75_sqx[30:0], 33'd0};
      s76_c2   <= sra64({{15{s75_p8l[48]}}, s75_p8l} + {s75_p8h, 32'd0}, 6'd19);
      s76_p    <= s75_p;
      s76_zero <= s75_zero;
      s77_sl   <= $signed({1'b0, s76_sq[31:0]}) * p9;
      s77_sh   <= s76_sq[63:32] * {{16{p9[15]}}, p9};
      s77_c2   <= s76_c2;
      s77_p    <= s76_p;
      s77_zero <= s76_zero;
      s78_c1   <= sra64({{15{s77_sl[48]}}, s77_sl} + {s77_sh, 32'd0}, 6'd25);
      s78_c2   <= s77_c2;
      s78_p    <= s77_p;
      s78_zero <= s77_zero;
      s79_press <= s78_zero ? 32'd0 : press_r[31:0];
      // temperature and humidity ride along
      tp[1] <= head.temp;
      for (int i = 2; i <= Lat; i++) begin
        tp[i] <= tp[i-1];
      end
      for (int i = HumDone + 1; i <= Lat; i++) begin
        hp[i] <= hp[i-1];
      end
    end
  end

  // restoring divide steps
  for (genvar j = 1; j <= DivSteps; j++) begin : g_div
    logic [31:0] sh;
    logic [31:0] diff;
    logic        ge;

    assign sh   = {div_rem[j-1], div_nq[j-1][63]};
    assign diff = sh - {1'b0, div_dd[j-1]};
    assign ge   = (sh >= {1'b0, div_dd[j-1]});

    always_ff @(posedge clk) begin
      if (adv) begin
        div_nq[j]   <= {div_nq[j-1][62:0], ge};
        div_neg[j]  <= div_neg[j-1];
        div_zero[j] <= div_zero[j-1];
      end
    end

    if (j < DivSteps) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          div_rem[j] <= ge ? diff[30:0] : sh[30:0];
          div_dd[j]  <= div_dd[j-1];
        end
      end
    end
  end

endmodule

@@ src/thp_sensor_compensation.sv @@
// Channel  Dir  Fields                                          Handshake
// sample   in   adc_temp, adc_press, adc_hum                    valid/ready
// result   out  temperature_centi, pressure_q24_8,
//               humidity_q22_10                                 valid/ready
// cfg      in   index, data (calibration words)                 valid/ready, always ready
//
// One reading set is taken per cycle while the front is not stalled; a result passes
// through 5 front stages, the queue and 79 back stages, including the 64-stage
// pipelined pressure divider in the back end.
// rst is synchronous and clears pipeline valids, queue pointers and calibration.
// A stalled result holds the whole back end; the front keeps taking requests
// until the queue between them and its own stages fill.
module thp_sensor_compensation #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  thp_in_if.sink    sample,
  thp_out_if.source result,
  thp_cfg_if.sink   cfg
);
  import thp_pkg::*;

  cal_t  cal;
  logic  push;
  logic  full;
  meas_t push_data;
  logic  pop;
  meas_t head;
  logic  head_valid;

  assign cfg.ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TEMP_CAL:   cal.temp_cal   <= cfg.data[47:0];
        REG_PRESS_LOW:  cal.press_low  <= cfg.data;
        REG_PRESS_HIGH: cal.press_high <= cfg.data;
        REG_PRESS_NINE: cal.press_nine <= cfg.data[15:0];
        REG_HUM_CAL:    cal.hum_cal    <= cfg.data;
        default:        cal <= cal;
      endcase
    end
  end

  thp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cal       (cal),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  thp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  thp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cal        (cal),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

@@ src/thp_checker.sv @@
module thp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_temp,
  input logic [31:0] out_press,
  input logic [16:0] out_hum
);

  // a waiting result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_temp) && $stable(out_press) && $stable(out_hum))
    else $error("result payload changed while stalled");

  // humidity clamp never exceeds 100 %RH
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_hum <= 17'd102400)
    else $error("humidity above full scale");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind thp_sensor_compensation thp_checker u_thp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_temp  (result.temperature_centi),
  .out_press (result.pressure_q24_8),
  .out_hum   (result.humidity_q22_10)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import thp_pkg::*;

  localparam int unsigned N_RANDOM_PER_CAL = 170;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  // index past the register list; the block must drop the write
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
  } reading_t;

  // compensation predictor and store of pending readings
  class thp_scoreboard;
    cal_t cal;
    reading_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      cal = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
      case (idx)
        REG_TEMP_CAL:   cal.temp_cal = d[47:0];
        REG_PRESS_LOW:  cal.press_low = d;
        REG_PRESS_HIGH: cal.press_high = d;
        REG_PRESS_NINE: cal.press_nine = d[15:0];
        REG_HUM_CAL:    cal.hum_cal = d;
        default: ;
      endcase
    endfunction

    function logic [31:0] asr_w(logic [31:0] v, int n);
      logic signed [31:0] s;
      s = $signed(v) >>> n;
      return s;
    endfunction

    function logic [63:0] asr_l(logic [63:0] v, int n);
      logic signed [63:0] s;
      s = $signed(v) >>> n;
      return s;
    endfunction

    function logic [63:0] sx16(logic [15:0] f);
      return {{48{f[15]}}, f};
    endfunction

    // truncating signed divide on 64-bit patterns, divisor nonzero
    function logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
      logic [63:0] nm, dm, q;
      nm = n[63] ? -n : n;
      dm = d[63] ? -d : d;
      q = nm / dm;
      return (n[63] ^ d[63]) ? -q : q;
    endfunction

    function reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      reading_t r;
      logic [31:0] at, ah, t1, t2, t3, v1, d2, v2, tfine;
      logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, hc, he, hf, v, s;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, ps, c1, c2;
      at = {12'd0, rt};
      ah = {16'd0, rh};
      // temperature, 32-bit wrap
      t1 = {16'd0, cal.temp_cal[15:0]};
      t2 = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
      t3 = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
      v1 = asr_w(((at >> 3) - (t1 << 1)) * t2, 11);
      d2 = (at >> 4) - t1;
      v2 = asr_w(asr_w(d2 * d2, 12) * t3, 14);
      tfine = v1 + v2;
      r.temp = asr_w(tfine * 32'd5 + 32'd128, 8);
      // pressure, 64-bit wrap
      p1 = {48'd0, cal.press_low[15:0]};
      p2 = sx16(cal.press_low[31:16]);
      p3 = sx16(cal.press_low[47:32]);
      p4 = sx16(cal.press_low[63:48]);
      p5 = sx16(cal.press_high[15:0]);
      p6 = sx16(cal.press_high[31:16]);
      p7 = sx16(cal.press_high[47:32]);
      p8 = sx16(cal.press_high[63:48]);
      p9 = sx16(cal.press_nine);
      a = {{32{tfine[31]}}, tfine} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = asr_l(a * a * p3, 8) + ((a * p2) << 12);
      a = asr_l(((64'd1 << 47) + a) * p1, 33);
      r.press = '0;
      if (a != 64'd0) begin
        p = 64'd1048576 - {44'd0, rp};
        p = div_trunc(((p << 31) - b) * 64'd3125, a);
        ps = asr_l(p, 13);
        c1 = asr_l(p9 * ps * ps, 25);
        c2 = asr_l(p8 * p, 19);
        p = asr_l(p + c1 + c2, 8) + (p7 << 4);
        r.press = p[31:0];
      end
      // humidity, 32-bit wrap, clamped to 0..100 %RH
      h1 = {24'd0, cal.hum_cal[7:0]};
      h2 = {{16{cal.hum_cal[23]}}, cal.hum_cal[23:8]};
      h3 = {24'd0, cal.hum_cal[31:24]};
      h4 = {{20{cal.hum_cal[43]}}, cal.hum_cal[43:32]};
      h5 = {{20{cal.hum_cal[55]}}, cal.hum_cal[55:44]};
      h6 = {{24{cal.hum_cal[63]}}, cal.hum_cal[63:56]};
      x = tfine - 32'd76800;
      ha = asr_w((ah << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
      hb = asr_w(x * h6, 10);
      hc = asr_w(x * h3, 11) + 32'd32768;
      he = asr_w(hb * hc, 10) + 32'd2097152;
      hf = asr_w(he * h2 + 32'd8192, 14);
      v = ha * hf;
      s = asr_w(v, 15);
      v = v - asr_w(asr_w(s * s, 7) * h1, 4);
      if (v[31]) v = '0;
      else if (v > HUM_MAX) v = HUM_MAX;
      r.hum = v[28:12];
      return r;
    endfunction

    function void note_request(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      pending.push_back(compensate(rt, rp, rh));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [31:0] t, logic [31:0] p, logic [16:0] h);
      reading_t e;
      if (pending.size() == 0) begin
        report("unexpected result", t, '0);
      end else begin
        e = pending.pop_front();
        checked++;
        if (t !== e.temp) report("temperature_centi", t, e.temp);
        if (p !== e.press) report("pressure_q24_8", p, e.press);
        if (h !== e.hum) report("humidity_q22_10", {15'd0, h}, {15'd0, e.hum});
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 75;
  int unsigned n_sent = 0;
  thp_scoreboard sb = new();

  thp_in_if  sample_if();
  thp_out_if result_if();
  thp_cfg_if cfg_if();

  thp_sensor_compensation DUT (
    .clk(clk),
    .rst(rst),
    .sample(sample_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  always #10 clk = ~clk;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.adc_temp = '0;
    sample_if.adc_press = '0;
    sample_if.adc_hum = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TEMP_CAL;
    cfg_if.data = '0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result monitor and run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_if.valid && result_if.ready)
      sb.check_result(result_if.temperature_centi, result_if.pressure_q24_8,
                      result_if.humidity_q22_10);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph, logic [63:0] p9,
                logic [63:0] hc);
    cfg_write(REG_TEMP_CAL, tc);
    cfg_write(REG_PRESS_LOW, pl);
    cfg_write(REG_PRESS_HIGH, ph);
    cfg_write(REG_PRESS_NINE, p9);
    cfg_write(REG_HUM_CAL, hc);
  endtask

  // valid stays up after acceptance until the next falling edge
  task send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid = 1'b0;
      @(negedge clk);
    end
    sample_if.valid = 1'b1;
    sample_if.adc_temp = rt;
    sample_if.adc_press = rp;
    sample_if.adc_hum = rh;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    sb.note_request(rt, rp, rh);
    n_sent++;
  endtask

  // wait until every pending reading is back
  task drain();
    @(negedge clk);
    sample_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_idle_for(int unsigned k, int unsigned total);
    if (k < total / 3) begin
      send_idle_pct = 24;
      recv_idle_pct = 75;
    end else if (k < 2 * total / 3) begin
      send_idle_pct = 75;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task random_readings(int unsigned count);
    logic [19:0] rt, rp;
    for (int unsigned k = 0; k < count; k++) begin
      set_idle_for(k, count);
      if ($urandom_range(0, 3) != 0) begin
        // plausible readings around room conditions
        rt = 20'($urandom_range(380000, 640000));
        rp = 20'($urandom_range(250000, 500000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      send_reading(rt, rp, 16'($urandom));
    end
  endtask

  task directed_readings();
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading('1, '0, '0);
    send_reading('0, '1, '1);
    send_reading(20'h80000, 20'h80000, 16'h8000);
    send_reading(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading(20'd415148, 20'd519888, 16'd0);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555);
  endtask

  initial begin
    logic [63:0] typ_t, typ_pl, typ_ph, typ_p9, typ_h;
    typ_t  = {16'hFFFF, 16'(-1000), 16'(26435), 16'(27504)};
    typ_pl = {16'(2855), 16'(3024), 16'(-10685), 16'(36477)};
    typ_ph = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
    typ_p9 = {48'hFFFF_FFFF_FFFF, 16'(6000)};
    typ_h  = {8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset calibration: pressure divisor term is zero
    directed_readings();
    random_readings(60);
    drain();

    // typical factory calibration; a stray write must be dropped
    load_cal(typ_t, typ_pl, typ_ph, typ_p9, typ_h);
    cfg_write(REG_UNUSED, '1);
    directed_readings();
    // humidity clamp at both ends
    send_reading(20'd519888, 20'd415148, 16'hFFFF);
    send_reading(20'd519888, 20'd415148, 16'd0);
    random_readings(N_RANDOM_PER_CAL + 10);
    drain();

    // all ones
    load_cal('1, '1, '1, '1, '1);
    directed_readings();
    random_readings(N_RANDOM_PER_CAL);
    drain();

    // most positive signed fields, P1 zero so the divisor vanishes
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, 64'h7FFF_7FFF_7FFF_0000,
             64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF, 64'h7F7F_F7FF_FF7F_FFFF);
    directed_readings();
    random_readings(60);
    drain();

    // random calibrations
    for (int ph = 0; ph < 2; ph++) begin
      load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      random_readings(N_RANDOM_PER_CAL);
      drain();
    end

    $display("sent %0d reading sets, checked %0d results in %0d cycles", n_sent,
             sb.checked, cycles);
    $display("covered reset, typical, all-ones, extreme and random calibrations");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/thp_pkg.sv
src/thp_if.sv
src/thp_front.sv
src/thp_queue.sv
src/thp_back.sv
src/thp_sensor_compensation.sv
src/thp_checker.sv
tb/tb.sv
